FILE: design/datl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datl_pkg: shared types and constants for the dual accelerometer tilt angle
// Sample and result payloads, datapath widths and the arctangent table.
// ----------------------------------------------------------------------------
package datl_pkg;

	// sample width and arctangent step count
	localparam int SAMPLE_BITS     = 16;
	localparam int ATAN_ITERATIONS = 16;

	localparam int TABLE_LEN = 24;
	localparam int NUM_STEPS = (ATAN_ITERATIONS < TABLE_LEN) ? ATAN_ITERATIONS : TABLE_LEN;
	localparam int PRESHIFT  = 24;

	localparam int GAIN_W = 8;
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(9);

	// gain*sample, difference and magnitude widths
	localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
	localparam int DIFF_W = PROD_W + 1;
	localparam int MAG_W  = PROD_W;
	// rotation registers: magnitude, preshift, cordic growth and sign
	localparam int CW     = MAG_W + PRESHIFT + 3;
	// angle accumulator in 2^-16 degree
	localparam int ZW     = 25;

	localparam int ANGLE_W = 16;
	localparam logic signed [ZW-1:0] QUARTER_Q16 = ZW'(90 * 65536);
	localparam logic signed [ANGLE_W-1:0] FULL_TILT = ANGLE_W'(23040);

	// multiply, difference, magnitude, cordic steps, output register
	localparam int LATENCY = NUM_STEPS + 4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] accel1_y;
		logic signed [SAMPLE_BITS-1:0] accel1_z;
		logic signed [SAMPLE_BITS-1:0] accel2_y;
		logic signed [SAMPLE_BITS-1:0] accel2_z;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] tilt_angle;
		logic                      angle_invalid;
	} result_t;

	// case flags that ride alongside the cordic pipeline
	typedef struct packed {
		logic invalid;
		logic mx_zero;
		logic my_zero;
		logic mx_neg;
		logic same_sign;
	} side_t;

	// round(atan(2^-i) * 180 / pi * 65536)
	function automatic logic [ZW-1:0] atan_q16(input int i);
		logic [ZW-1:0] t;
		case (i)
			0: t = ZW'(2949120);
			1: t = ZW'(1740967);
			2: t = ZW'(919879);
			3: t = ZW'(466945);
			4: t = ZW'(234379);
			5: t = ZW'(117304);
			6: t = ZW'(58666);
			7: t = ZW'(29335);
			8: t = ZW'(14668);
			9: t = ZW'(7334);
			10: t = ZW'(3667);
			11: t = ZW'(1833);
			12: t = ZW'(917);
			13: t = ZW'(458);
			14: t = ZW'(229);
			15: t = ZW'(115);
			16: t = ZW'(57);
			17: t = ZW'(29);
			18: t = ZW'(14);
			19: t = ZW'(7);
			20: t = ZW'(4);
			21: t = ZW'(2);
			22: t = ZW'(1);
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

FILE: design/datl_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datl_cordic: pipelined vectoring cordic
// One rotation step per register stage; flags travel with each stage.
// ----------------------------------------------------------------------------
module datl_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [datl_pkg::CW-1:0]    in_x,
	input  logic signed [datl_pkg::CW-1:0]    in_y,
	input  datl_pkg::side_t                   in_side,
	output logic                              out_valid,
	output logic signed [datl_pkg::ZW-1:0]    out_z,
	output datl_pkg::side_t                   out_side
);

	localparam int N = datl_pkg::NUM_STEPS;

	logic                           v_s    [1:N];
	logic signed [datl_pkg::CW-1:0] x_s    [1:N];
	logic signed [datl_pkg::CW-1:0] y_s    [1:N];
	logic signed [datl_pkg::ZW-1:0] z_s    [1:N];
	datl_pkg::side_t                side_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic                           vi;
		logic signed [datl_pkg::CW-1:0] xi;
		logic signed [datl_pkg::CW-1:0] yi;
		logic signed [datl_pkg::ZW-1:0] zi;
		datl_pkg::side_t                si;
		logic signed [datl_pkg::ZW-1:0] t;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign xi = in_x;
			assign yi = in_y;
			assign zi = '0;
			assign si = in_side;
		end else begin : g_next
			assign vi = v_s[k];
			assign xi = x_s[k];
			assign yi = y_s[k];
			assign zi = z_s[k];
			assign si = side_s[k];
		end

		assign t = $signed(datl_pkg::atan_q16(k));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			// rotate toward the x axis by the sign of y
			if (!yi[datl_pkg::CW-1]) begin
				x_s[k+1] <= xi + (yi >>> k);
				y_s[k+1] <= yi - (xi >>> k);
				z_s[k+1] <= zi + t;
			end else begin
				x_s[k+1] <= xi - (yi >>> k);
				y_s[k+1] <= yi + (xi >>> k);
				z_s[k+1] <= zi - t;
			end
			side_s[k+1] <= si;
		end
	end

	assign out_valid = v_s[N];
	assign out_z     = z_s[N];
	assign out_side  = side_s[N];

	a_valid_travel: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##(N) out_valid)
		else $error("cordic lost a request");

endmodule

FILE: design/dual_accel_tilt_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_accel_tilt_angle: tilt angle from two accelerometers
// Weighted difference of the two sensors, then atan(-mx/my) in 1/256 degree.
// ----------------------------------------------------------------------------
// done rises after the multiply, difference, magnitude, cordic and output register stages
// throughput: one request per cycle, busy is always low; one cordic step per stage
// the result is shown for one cycle with done and cannot be held off
// reset clears all valid bits and loads gain_q with 9; data registers are not reset
module dual_accel_tilt_angle (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  datl_pkg::sample_t                     sample,
	output logic                                  done,
	output datl_pkg::result_t                     result,
	input  logic                                  cfg_we,
	input  logic [datl_pkg::GAIN_W-1:0]           cfg_wdata
);

	logic [datl_pkg::GAIN_W-1:0] gain_q;

	logic                                   v_s1;
	logic signed [datl_pkg::SAMPLE_BITS-1:0] y1_s1;
	logic signed [datl_pkg::SAMPLE_BITS-1:0] z1_s1;
	logic signed [datl_pkg::PROD_W-1:0]      py_s1;
	logic signed [datl_pkg::PROD_W-1:0]      pz_s1;

	logic                                   v_s2;
	logic signed [datl_pkg::DIFF_W-1:0]      mx_s2;
	logic signed [datl_pkg::DIFF_W-1:0]      my_s2;

	logic                                   v_s3;
	logic signed [datl_pkg::CW-1:0]          x_s3;
	logic signed [datl_pkg::CW-1:0]          y_s3;
	datl_pkg::side_t                         side_s3;

	logic signed [datl_pkg::PROD_W-1:0]      gain_ext;
	logic [datl_pkg::MAG_W-1:0]              amx;
	logic [datl_pkg::MAG_W-1:0]              amy;
	logic [datl_pkg::DIFF_W-1:0]             neg_mx;
	logic [datl_pkg::DIFF_W-1:0]             neg_my;

	logic                                   cv;
	logic signed [datl_pkg::ZW-1:0]          cz;
	datl_pkg::side_t                         cside;

	logic signed [datl_pkg::ZW-1:0]          zc;
	logic [datl_pkg::ZW-1:0]                 rnd;
	logic signed [datl_pkg::ANGLE_W-1:0]     mag;
	datl_pkg::result_t                       res_d;

	logic                                   done_q;
	datl_pkg::result_t                       result_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= datl_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	assign gain_ext = $signed(datl_pkg::PROD_W'(gain_q));

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start && !busy;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= cv;
		end
	end

	// stage 1: weight the second sensor
	always_ff @(posedge clk) begin
		y1_s1 <= sample.accel1_y;
		z1_s1 <= sample.accel1_z;
		py_s1 <= datl_pkg::PROD_W'(sample.accel2_y) * gain_ext;
		pz_s1 <= datl_pkg::PROD_W'(sample.accel2_z) * gain_ext;
	end

	// stage 2: differences
	always_ff @(posedge clk) begin
		mx_s2 <= datl_pkg::DIFF_W'(z1_s1) - datl_pkg::DIFF_W'(pz_s1);
		my_s2 <= datl_pkg::DIFF_W'(y1_s1) - datl_pkg::DIFF_W'(py_s1);
	end

	// stage 3: magnitudes and case flags
	assign neg_mx = -mx_s2;
	assign neg_my = -my_s2;
	assign amx = mx_s2[datl_pkg::DIFF_W-1] ? neg_mx[datl_pkg::MAG_W-1:0]
		: mx_s2[datl_pkg::MAG_W-1:0];
	assign amy = my_s2[datl_pkg::DIFF_W-1] ? neg_my[datl_pkg::MAG_W-1:0]
		: my_s2[datl_pkg::MAG_W-1:0];

	always_ff @(posedge clk) begin
		x_s3              <= $signed(datl_pkg::CW'({amy, datl_pkg::PRESHIFT'(0)}));
		y_s3              <= $signed(datl_pkg::CW'({amx, datl_pkg::PRESHIFT'(0)}));
		side_s3.mx_zero   <= (mx_s2 == '0);
		side_s3.my_zero   <= (my_s2 == '0);
		side_s3.invalid   <= (mx_s2 == '0) && (my_s2 == '0);
		side_s3.mx_neg    <= mx_s2[datl_pkg::DIFF_W-1];
		side_s3.same_sign <= mx_s2[datl_pkg::DIFF_W-1] == my_s2[datl_pkg::DIFF_W-1];
	end

	datl_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_x      (x_s3),
		.in_y      (y_s3),
		.in_side   (side_s3),
		.out_valid (cv),
		.out_z     (cz),
		.out_side  (cside)
	);

	// clamp to the first quadrant, round to 1/256 degree, restore sign; zero differences override
	always_comb begin
		if (cz[datl_pkg::ZW-1]) begin
			zc = '0;
		end else if (cz > datl_pkg::QUARTER_Q16) begin
			zc = datl_pkg::QUARTER_Q16;
		end else begin
			zc = cz;
		end
		rnd = zc + datl_pkg::ZW'(128);
		mag = $signed(rnd[datl_pkg::ANGLE_W+7:8]);

		res_d.angle_invalid = 1'b0;
		if (cside.invalid) begin
			res_d.tilt_angle    = '0;
			res_d.angle_invalid = 1'b1;
		end else if (cside.my_zero) begin
			res_d.tilt_angle = cside.mx_neg ? datl_pkg::FULL_TILT : -datl_pkg::FULL_TILT;
		end else if (cside.mx_zero) begin
			res_d.tilt_angle = '0;
		end else begin
			res_d.tilt_angle = cside.same_sign ? -mag : mag;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(datl_pkg::LATENCY) done)
		else $error("request did not complete on time");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.angle_invalid) |-> (result.tilt_angle == '0))
		else $error("invalid result carries a nonzero angle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.tilt_angle <= datl_pkg::FULL_TILT
			&& result.tilt_angle >= -datl_pkg::FULL_TILT))
		else $error("tilt angle out of range");

	a_gain_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (gain_q == $past(cfg_wdata)))
		else $error("gain write not taken");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dual accelerometer tilt angle block
// Walks a short table of corner-case samples, then random sample phases at
// several gains, and checks every strobed angle against a typed expectation or a cordic predictor.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int MAX_REPORTS  = 10;
	localparam int ANGLE_STEPS  =
		(datl_pkg::ATAN_ITERATIONS < 24) ? datl_pkg::ATAN_ITERATIONS : 24;

	// atan(2^-i) in 2^-16 degree
	localparam longint ATAN_DEG16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic [datl_pkg::GAIN_W-1:0] gain;
		datl_pkg::sample_t           s;
		bit                          typed;
		datl_pkg::result_t           res;
	} corner_row_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	datl_pkg::sample_t           sample = '0;
	logic                        done;
	datl_pkg::result_t           result;
	logic                        cfg_we = 1'b0;
	logic [datl_pkg::GAIN_W-1:0] cfg_wdata = '0;

	// what the next request carries for the checker
	bit                          req_typed = 1'b0;
	datl_pkg::result_t           req_res = '0;

	logic [datl_pkg::GAIN_W-1:0] gain_shadow = datl_pkg::GAIN_RESET;
	datl_pkg::result_t           pending_angles [$];
	corner_row_t                 corner_rows [$];
	datl_pkg::result_t           want_r;

	int cycles = 0;
	int n_mismatch = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_invalid = 0;
	int n_vertical = 0;
	int n_gains = 0;

	dual_accel_tilt_angle u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.sample    (sample),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic datl_pkg::result_t tilt_predict(datl_pkg::sample_t s,
			logic [datl_pkg::GAIN_W-1:0] g);
		longint gl, mx, my, amx, amy, x, y, z, xs, ys, ang;
		datl_pkg::result_t r;
		gl = longint'(g);
		mx = longint'($signed(s.accel1_z)) - gl * longint'($signed(s.accel2_z));
		my = longint'($signed(s.accel1_y)) - gl * longint'($signed(s.accel2_y));
		r.angle_invalid = 1'b0;
		if (mx == 0 && my == 0) begin
			ang = 0;
			r.angle_invalid = 1'b1;
		end else if (my == 0) begin
			ang = (mx < 0) ? 23040 : -23040;
		end else if (mx == 0) begin
			ang = 0;
		end else begin
			amx = (mx < 0) ? -mx : mx;
			amy = (my < 0) ? -my : my;
			x = amy <<< datl_pkg::PRESHIFT;
			y = amx <<< datl_pkg::PRESHIFT;
			z = 0;
			for (int i = 0; i < ANGLE_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ATAN_DEG16[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ATAN_DEG16[i];
				end
			end
			if (z < 0) z = 0;
			if (z > 90 * 65536) z = 90 * 65536;
			ang = (z + 128) >>> 8;
			if ((mx < 0) == (my < 0)) ang = -ang;
		end
		r.tilt_angle = ang[datl_pkg::ANGLE_W-1:0];
		return r;
	endfunction

	// uniform integer in [-lo, hi]
	function automatic int rand_span(int lo, int hi);
		return int'($urandom_range(lo + hi, 0)) - lo;
	endfunction

	function automatic int corner_value();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic datl_pkg::sample_t rand_sample(logic [datl_pkg::GAIN_W-1:0] g);
		datl_pkg::sample_t s;
		int mode, lo, hi, y2, z2;
		mode = $urandom_range(0, 99);
		s = datl_pkg::sample_t'({$urandom, $urandom});
		lo = (g == 0) ? 32768 : 32768 / g;
		hi = (g == 0) ? 32767 : 32767 / g;
		if (mode < 40) begin
			// full range as drawn
		end else if (mode < 55) begin
			s.accel1_y = 16'(corner_value());
			s.accel1_z = 16'(corner_value());
			s.accel2_y = 16'(corner_value());
			s.accel2_z = 16'(corner_value());
		end else if (mode < 65) begin
			s.accel1_y = 16'(rand_span(8, 8));
			s.accel1_z = 16'(rand_span(8, 8));
			s.accel2_y = 16'(rand_span(8, 8));
			s.accel2_z = 16'(rand_span(8, 8));
		end else if (mode < 88) begin
			// cancel one or both differences exactly
			y2 = rand_span(lo, hi);
			z2 = rand_span(lo, hi);
			if (mode < 75 || mode >= 83) begin
				s.accel2_y = 16'(y2);
				s.accel1_y = 16'(int'(g) * y2);
			end
			if (mode >= 75) begin
				s.accel2_z = 16'(z2);
				s.accel1_z = 16'(int'(g) * z2);
			end
		end else begin
			// second sensor scaled into the range of the first
			s.accel2_y = 16'(rand_span(lo, hi));
			s.accel2_z = 16'(rand_span(lo, hi));
		end
		return s;
	endfunction

	function automatic void add_row(int g, int y1, int z1, int y2, int z2,
			bit typed, int ang, bit inv);
		corner_row_t row;
		row.gain = datl_pkg::GAIN_W'(g);
		row.s.accel1_y = 16'(y1);
		row.s.accel1_z = 16'(z1);
		row.s.accel2_y = 16'(y2);
		row.s.accel2_z = 16'(z2);
		row.typed = typed;
		row.res.tilt_angle = 16'(ang);
		row.res.angle_invalid = inv;
		corner_rows.push_back(row);
	endfunction

	task automatic send_request(datl_pkg::sample_t s, bit typed, datl_pkg::result_t r);
		@(negedge clk);
		start <= 1'b1;
		sample <= s;
		req_typed <= typed;
		req_res <= r;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// wait out every outstanding angle, then load a new gain
	task automatic set_gain(logic [datl_pkg::GAIN_W-1:0] g);
		@(negedge clk);
		start <= 1'b0;
		while (pending_angles.size() != 0) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(negedge clk);
		cfg_we <= 1'b0;
		n_gains++;
	endtask

	// checker: results first, then the request accepted at this edge
	always @(posedge clk) begin
		if (!arst_n) begin
			gain_shadow = datl_pkg::GAIN_RESET;
		end else begin
			if (done) begin
				n_checked++;
				if (result.angle_invalid) n_invalid++;
				if (result.tilt_angle == 16'sd23040 || result.tilt_angle == -16'sd23040)
					n_vertical++;
				if (pending_angles.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= MAX_REPORTS)
						$display("unexpected result: angle %0d invalid %0b",
							result.tilt_angle, result.angle_invalid);
				end else begin
					want_r = pending_angles.pop_front();
					if (result.tilt_angle !== want_r.tilt_angle ||
							result.angle_invalid !== want_r.angle_invalid) begin
						n_mismatch++;
						if (n_mismatch <= MAX_REPORTS)
							$display("mismatch at result %0d: angle exp %0d got %0d, invalid exp %0b got %0b",
								n_checked, want_r.tilt_angle, result.tilt_angle,
								want_r.angle_invalid, result.angle_invalid);
					end
				end
			end
			if (start && !busy) begin
				n_accepted++;
				pending_angles.push_back(req_typed ? req_res : tilt_predict(sample, gain_shadow));
			end
			if (cfg_we) gain_shadow = cfg_wdata;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_angles.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [datl_pkg::GAIN_W-1:0] cur_gain;
		logic [datl_pkg::GAIN_W-1:0] g;
		int sent, phase_len, idle_pct;
		bit quiet;
		datl_pkg::result_t none;

		none = '0;
		cur_gain = datl_pkg::GAIN_RESET;

		// corner table: typed expectations only where they are obvious
		add_row(9, 0, 0, 0, 0, 1, 0, 1);
		add_row(9, 9, 0, 1, 1, 1, 23040, 0);
		add_row(9, 0, 5, 0, 0, 1, -23040, 0);
		add_row(9, 100, 0, 0, 0, 1, 0, 0);
		add_row(9, 32767, 32767, -32768, -32768, 0, 0, 0);
		add_row(9, -32768, 32767, 32767, -32768, 0, 0, 0);
		add_row(0, 32767, -32768, -1, -1, 0, 0, 0);
		add_row(0, 0, -32768, 5, 5, 1, 23040, 0);
		add_row(0, -32768, 0, 7, 7, 1, 0, 0);
		add_row(0, 32767, 0, 0, 0, 1, 0, 0);
		add_row(0, 1, 1, 0, 0, 0, 0, 0);
		add_row(255, 32767, -32768, -32768, 32767, 0, 0, 0);
		add_row(255, 255, -255, 1, -1, 1, 0, 1);
		add_row(255, -32768, 32767, -32768, 32767, 0, 0, 0);
		add_row(255, 32767, 1, 0, 0, 0, 0, 0);
		add_row(255, -32768, -32768, 32767, 32767, 0, 0, 0);
		add_row(1, -5, 3, -5, 0, 1, -23040, 0);
		add_row(1, -1, -1, 0, 0, 0, 0, 0);
		add_row(128, -32768, -32768, 32767, 32767, 0, 0, 0);
		add_row(128, 32767, -32768, 256, -256, 0, 0, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (corner_rows[i]) begin
			if (corner_rows[i].gain != cur_gain) begin
				set_gain(corner_rows[i].gain);
				cur_gain = corner_rows[i].gain;
			end
			send_request(corner_rows[i].s, corner_rows[i].typed, corner_rows[i].res);
			if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 12));
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: g = 8'd0;
				1: g = 8'd255;
				2: g = 8'd1;
				3: g = datl_pkg::GAIN_RESET;
				default: g = datl_pkg::GAIN_W'($urandom);
			endcase
			set_gain(g);
			quiet = (sent >= RANDOM_ITEMS - 300);
			phase_len = quiet ? RANDOM_ITEMS - sent : $urandom_range(100, 300);
			// keep the closing stretch free of idling
			if (!quiet && phase_len > RANDOM_ITEMS - 300 - sent)
				phase_len = RANDOM_ITEMS - 300 - sent;
			idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
			repeat (phase_len) begin
				send_request(rand_sample(g), 1'b0, none);
				sent++;
				if (!quiet && $urandom_range(0, 99) < idle_pct)
					hold_off($urandom_range(1, 12));
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (datl_pkg::LATENCY + 8) @(posedge clk);

		if (pending_angles.size() != 0) n_mismatch += pending_angles.size();
		$display("requests %0d, results checked %0d, gain settings %0d",
			n_accepted, n_checked, n_gains);
		$display("undefined angles %0d, vertical angles %0d, mismatches %0d",
			n_invalid, n_vertical, n_mismatch);
		if (n_mismatch == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
